// ===== rtl/catau_pkg.sv =====
// catau_pkg: shared types and constants for the centroid-to-tilt unit.
// No dependencies.
`timescale 1ns / 1ps
package catau_pkg;

  localparam int AngleMax = 5898240;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_SETUP,
    ST_DIV,
    ST_SQ,
    ST_SQRT,
    ST_ANG_SETUP,
    ST_MUL,
    ST_NORM,
    ST_CORDIC,
    ST_ANG_DONE,
    ST_OUT
  } state_t;

  // register indexes
  localparam logic [2:0] REG_BASE_X = 3'd0;
  localparam logic [2:0] REG_BASE_Y = 3'd1;
  localparam logic [2:0] REG_PITCH  = 3'd2;
  localparam logic [2:0] REG_FOCAL  = 3'd3;
  localparam logic [2:0] REG_AVG    = 3'd4;

  // atan(2^-i) in degrees * 65536
  function automatic logic [21:0] atan_lut(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0: r = 22'd2949120;  5'd1: r = 22'd1740967;  5'd2: r = 22'd919879;
      5'd3: r = 22'd466945;   5'd4: r = 22'd234379;   5'd5: r = 22'd117304;
      5'd6: r = 22'd58666;    5'd7: r = 22'd29335;    5'd8: r = 22'd14668;
      5'd9: r = 22'd7334;     5'd10: r = 22'd3667;    5'd11: r = 22'd1833;
      5'd12: r = 22'd917;     5'd13: r = 22'd458;     5'd14: r = 22'd229;
      5'd15: r = 22'd115;     5'd16: r = 22'd57;      5'd17: r = 22'd29;
      5'd18: r = 22'd14;      5'd19: r = 22'd7;       5'd20: r = 22'd4;
      5'd21: r = 22'd2;       5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/catau_cordic.sv =====
// catau_cordic: iterative vectoring CORDIC, one micro-rotation per cycle.
// Depends on catau_pkg. Operands arrive already normalized so the larger lies in [2^39, 2^40).
`timescale 1ns / 1ps
module catau_cordic #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [40:0] num,
  input  logic [40:0] den,
  output logic        done,
  output logic [22:0] angle
);
  import catau_pkg::*;

  localparam int SW = $clog2(CORDIC_STEPS + 1);

  logic signed [43:0] x, y;
  logic signed [31:0] z;
  logic [SW-1:0]      step;
  logic               busy;
  logic [5:0]         sh;
  logic signed [43:0] xs, ys;

  // shift with truncation toward zero
  assign sh = 6'(step);
  assign ys = y[43] ? -((-y) >>> sh) : (y >>> sh);
  assign xs = x[43] ? -((-x) >>> sh) : (x >>> sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x <= 44'(den);
        y <= 44'(num);
        z <= '0;
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + 32'(atan_lut(5'(step)));
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - 32'(atan_lut(5'(step)));
        end
        if (step == SW'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  assign angle = (z < 0) ? '0 : (z > AngleMax) ? 23'(AngleMax) : 23'(z);

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("cordic done while busy");
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("cordic did not start");
  assert property (@(posedge clk) disable iff (rst) busy |-> step < SW'(CORDIC_STEPS))
    else $error("cordic step overrun");

endmodule

// ===== rtl/centroid_average_to_tilt_angle_unit.sv =====
// Top level of the centroid-to-tilt unit: APB registers, window ring, sequencer.
// Depends on catau_pkg and catau_cordic.
`timescale 1ns / 1ps
// One detected centre per beat goes in; one result beat comes out. The unit
// works on one centre at a time: in_stall is high from acceptance until the
// result beat is taken. A centre re-forms the window sums, then runs the two
// divides, the square root and the three angles in turn, then raises the
// result. Each angle first scales its numerator and denominator, then goes
// through the one CORDIC unit that all three angles share; an angle with a
// zero numerator skips the CORDIC. Division, square root and magnitude
// scaling run as shift/subtract steps in turn. A rejected centre (x zero, or
// pitch or focal zero) gives its all-zero result on the cycle after
// acceptance. The ring is a memory read one entry per cycle while the sums
// are re-formed; entries never written are never summed, so the ring needs
// no clearing.
module centroid_average_to_tilt_angle_unit #(
  parameter int WINDOW_DEPTH = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] center_x,
  input  logic [15:0] center_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic [15:0] mean_x,
  output logic [15:0] mean_y,
  output logic signed [16:0] offset_h,
  output logic signed [16:0] offset_v,
  output logic [22:0] tilt_total,
  output logic signed [23:0] tilt_x,
  output logic signed [23:0] tilt_y
);
  import catau_pkg::*;

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SUMW = 16 + CW;

  // configuration registers
  logic [15:0] base_x, base_y;
  logic [16:0] pixel_pitch_nm;
  logic [19:0] focal_length_um;
  logic [3:0]  average_extra;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_x          <= 16'd16384;
      base_y          <= 16'd16384;
      pixel_pitch_nm  <= 17'd5500;
      focal_length_um <= 20'd94450;
      average_extra   <= 4'd0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_BASE_X: base_x          <= pwdata[15:0];
        REG_BASE_Y: base_y          <= pwdata[15:0];
        REG_PITCH:  pixel_pitch_nm  <= pwdata[16:0];
        REG_FOCAL:  focal_length_um <= pwdata[19:0];
        REG_AVG:    average_extra   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE_X: prdata = {16'd0, base_x};
      REG_BASE_Y: prdata = {16'd0, base_y};
      REG_PITCH:  prdata = {15'd0, pixel_pitch_nm};
      REG_FOCAL:  prdata = {12'd0, focal_length_um};
      REG_AVG:    prdata = {28'd0, average_extra};
      default:    prdata = '0;
    endcase
  end

  // window ring
  logic [15:0] ring_x [WINDOW_DEPTH];
  logic [15:0] ring_y [WINDOW_DEPTH];
  logic [AW-1:0] write_slot, rd_addr;
  logic [15:0]   rd_x, rd_y;
  logic          ring_we;
  logic [CW-1:0] fill_count;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_x[write_slot] <= center_x;
      ring_y[write_slot] <= center_y;
    end
    rd_x <= ring_x[rd_addr];
    rd_y <= ring_y[rd_addr];
  end

  // sequencer
  state_t state, state_next;
  logic   take;
  logic   [CW:0] k;          // sum counter, one extra for read latency
  logic   [SUMW-1:0] sum_x, sum_y;
  logic   [1:0] phase;       // which axis/angle is in flight
  logic   [6:0] cnt;
  // divider (both axes) / root registers
  logic   [SUMW+CW:0] rem;
  logic   [SUMW-1:0]  quo;
  logic   [SUMW-1:0]  dividend;
  logic   [49:0]      sq_v, sq_r, sq_bit;
  logic   [33:0]      mag;   // root, 2^-8 pixel
  logic   [63:0]      an_num, an_den;
  logic               cd_start, cd_done;
  logic   [22:0]      cd_angle;
  logic   [16:0]      abs_h, abs_v;
  logic   [33:0]      mag_sel;
  logic   [15:0]      mx_r;
  logic               bad;
  logic   [CW-1:0]    win_n;

  assign take     = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE) || out_valid;
  assign bad      = (center_x == 16'd0) || (pixel_pitch_nm == '0) || (focal_length_um == '0);
  assign win_n    = ((32'(average_extra) + 1) > WINDOW_DEPTH) ? CW'(WINDOW_DEPTH)
                                                               : CW'(32'(average_extra) + 1);
  assign ring_we  = take && !bad;
  assign abs_h    = offset_h[16] ? 17'(-offset_h) : 17'(offset_h);
  assign abs_v    = offset_v[16] ? 17'(-offset_v) : 17'(offset_v);
  assign mag_sel  = (phase == 2'd0) ? mag : (phase == 2'd1) ? 34'(abs_h) : 34'(abs_v);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cd_start   = 1'b0;
    case (state)
      ST_IDLE:      if (take && !bad) state_next = ST_SUM;
      ST_SUM:       if (k == {1'b0, fill_count}) state_next = ST_DIV_SETUP;
      ST_DIV_SETUP: state_next = ST_DIV;
      ST_DIV:       if (cnt == 7'(SUMW)) state_next =
                        (phase == 2'd1) ? ST_SQ : ST_DIV_SETUP;
      ST_SQ:        state_next = ST_SQRT;
      ST_SQRT:      if (sq_bit == '0) state_next = ST_ANG_SETUP;
      ST_ANG_SETUP: state_next = ST_MUL;
      ST_MUL:       state_next = ST_NORM;
      ST_NORM:      if (an_num == '0) state_next = ST_ANG_DONE;
                    else if ((an_num | an_den) >= 64'(1) << 40 ||
                             (an_num | an_den) < 64'(1) << 39) state_next = ST_NORM;
                    else begin
                      state_next = ST_CORDIC;
                      cd_start   = 1'b1;
                    end
      ST_CORDIC:    if (cd_done) state_next = ST_ANG_DONE;
      ST_ANG_DONE:  state_next = (phase == 2'd2) ? ST_OUT : ST_ANG_SETUP;
      ST_OUT:       state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  logic [63:0] big;
  assign big = (an_num > an_den) ? an_num : an_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      write_slot <= '0;
      fill_count <= '0;
      phase      <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (take) begin
          if (bad) begin
            out_valid <= 1'b1;
            accepted <= 1'b0; mean_x <= '0; mean_y <= '0;
            offset_h <= '0; offset_v <= '0;
            tilt_total <= '0; tilt_x <= '0; tilt_y <= '0;
          end else begin
            write_slot <= (32'(write_slot) == WINDOW_DEPTH - 1) ? '0 : write_slot + 1'b1;
            fill_count <= (fill_count + 1'b1 > win_n) ? win_n : fill_count + 1'b1;
            rd_addr <= write_slot;
            k <= '0;
            sum_x <= '0; sum_y <= '0;
            phase <= '0;
          end
        end
        ST_SUM: begin
          rd_addr <= (rd_addr == '0) ? AW'(WINDOW_DEPTH - 1) : rd_addr - 1'b1;
          k <= k + 1'b1;
          if (k != '0) begin
            sum_x <= sum_x + SUMW'(rd_x);
            sum_y <= sum_y + SUMW'(rd_y);
          end
        end
        ST_DIV_SETUP: begin
          dividend <= ((phase == 2'd0) ? sum_x : sum_y) + SUMW'(fill_count >> 1);
          rem <= '0; quo <= '0; cnt <= '0;
        end
        ST_DIV: if (cnt != 7'(SUMW)) begin
          // restoring division, one quotient bit per cycle
          if ({rem[SUMW+CW-1:0], dividend[SUMW-1]} >= (SUMW+CW+1)'(fill_count)) begin
            rem <= {rem[SUMW+CW-1:0], dividend[SUMW-1]} - (SUMW+CW+1)'(fill_count);
            quo <= {quo[SUMW-2:0], 1'b1};
          end else begin
            rem <= {rem[SUMW+CW-1:0], dividend[SUMW-1]};
            quo <= {quo[SUMW-2:0], 1'b0};
          end
          dividend <= dividend << 1;
          cnt <= cnt + 1'b1;
        end else begin
          if (phase == 2'd0) begin
            mx_r <= quo[15:0];
            phase <= 2'd1;
          end else begin
            mean_x <= mx_r;
            mean_y <= quo[15:0];
            offset_h <= 17'($signed({1'b0, mx_r}) - $signed({1'b0, base_x}));
            offset_v <= 17'($signed({1'b0, quo[15:0]}) - $signed({1'b0, base_y}));
          end
        end
        ST_SQ: begin
          sq_v   <= 50'(34'(abs_h) * 34'(abs_h) + 34'(abs_v) * 34'(abs_v)) << 16;
          sq_r   <= '0;
          sq_bit <= 50'(1) << 48;
          phase  <= 2'd0;
        end
        ST_SQRT: begin
          if (sq_v >= sq_r + sq_bit) begin
            sq_v <= sq_v - (sq_r + sq_bit);
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit == '0) mag <= sq_r[33:0];
        end
        ST_ANG_SETUP: mag <= (phase == 2'd0) ? mag : mag;
        ST_MUL: begin
          an_num <= 64'(mag_sel) * 64'(pixel_pitch_nm);
          an_den <= (phase == 2'd0) ? 64'(focal_length_um) * 64'd4096000
                                    : 64'(focal_length_um) * 64'd16000;
        end
        ST_NORM: begin
          if (big >= 64'(1) << 40) begin
            an_num <= an_num >> 1; an_den <= an_den >> 1;
          end else if (big < 64'(1) << 39) begin
            an_num <= an_num << 1; an_den <= an_den << 1;
          end
        end
        ST_ANG_DONE: begin
          case (phase)
            2'd0: tilt_total <= (an_num == '0) ? '0 : cd_angle;
            2'd1: tilt_x <= (an_num == '0) ? '0 :
                           offset_h[16] ? -24'(cd_angle) : 24'(cd_angle);
            default: tilt_y <= (an_num == '0) ? '0 :
                           offset_v[16] ? -24'(cd_angle) : 24'(cd_angle);
          endcase
          phase <= phase + 1'b1;
        end
        ST_OUT: begin
          accepted  <= 1'b1;
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  catau_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cd_start),
    .num   (an_num[40:0]),
    .den   (an_den[40:0]),
    .done  (cd_done),
    .angle (cd_angle)
  );

  assert property (@(posedge clk) disable iff (rst) take |=> in_stall)
    else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == ST_IDLE)
    else $error("result pending while working");
  assert property (@(posedge clk) disable iff (rst) fill_count <= CW'(WINDOW_DEPTH))
    else $error("fill count overrun");
  assert property (@(posedge clk) disable iff (rst)
                   (state == ST_OUT) |=> out_valid && accepted)
    else $error("result not raised");

endmodule

// ===== test/centroid_average_to_tilt_angle_unit_test.sv =====
// Self-checking bench for centroid_average_to_tilt_angle_unit: APB setup, centre
// beats in, tilt result beats out, checked against an in-bench angle predictor.
// Depends on catau_pkg and the unit RTL.
`timescale 1ns / 1ps
module centroid_average_to_tilt_angle_unit_test;
  import catau_pkg::*;

  localparam int RING_DEPTH = 16;
  localparam int ARC_STEPS = 24;
  localparam int STALL_LIMIT = 20000;   // cycles with no beat on either side
  localparam int LONG_HOLD = 800;       // receiver back-pressure stretch

  // arctan(2^-i) in degrees * 65536
  localparam longint ARC_STEP [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0};

  typedef struct packed {
    logic               accepted;
    logic [15:0]        mean_x;
    logic [15:0]        mean_y;
    logic signed [16:0] offset_h;
    logic signed [16:0] offset_v;
    logic [22:0]        tilt_total;
    logic signed [23:0] tilt_x;
    logic signed [23:0] tilt_y;
  } tilt_beat_t;

  // Tracks window state and optics settings; predicts one result per centre.
  class tilt_scoreboard;
    bit [15:0] base_x = 16384, base_y = 16384;
    bit [16:0] pitch = 5500;
    bit [19:0] focal = 94450;
    bit [3:0]  avg_extra = 0;
    bit [15:0] ring_x [RING_DEPTH];
    bit [15:0] ring_y [RING_DEPTH];
    int        fill = 0, slot = 0;
    tilt_beat_t pending[$];
    int        mismatches = 0;

    function void set_reg(logic [2:0] idx, bit [31:0] val);
      case (idx)
        REG_BASE_X: base_x = val[15:0];
        REG_BASE_Y: base_y = val[15:0];
        REG_PITCH:  pitch = val[16:0];
        REG_FOCAL:  focal = val[19:0];
        REG_AVG:    avg_extra = val[3:0];
        default: ;
      endcase
    endfunction

    function longint shr_tz(longint v, int s);
      if (v < 0) return -((-v) >> s);
      return v >> s;
    endfunction

    function bit [63:0] isqrt(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint arc_angle(bit [63:0] num, bit [63:0] den);
      bit [63:0] big;
      longint x, y, z, nx;
      if (num == 0) return 0;
      big = (num > den) ? num : den;
      while (big >= (64'd1 << 40)) begin
        num = num >> 1; den = den >> 1; big = big >> 1;
      end
      while (big < (64'd1 << 39)) begin
        num = num << 1; den = den << 1; big = big << 1;
      end
      if (num == 0) return 0;
      x = den;
      y = num;
      z = 0;
      for (int i = 0; i < ARC_STEPS; i++) begin
        if (y >= 0) begin
          nx = x + shr_tz(y, i);
          y = y - shr_tz(x, i);
          z += ARC_STEP[i];
        end else begin
          nx = x - shr_tz(y, i);
          y = y + shr_tz(x, i);
          z -= ARC_STEP[i];
        end
        x = nx;
      end
      if (z < 0) z = 0;
      if (z > AngleMax) z = AngleMax;
      return z;
    endfunction

    function longint axis_tilt(longint d);
      bit [63:0] mag;
      longint a;
      mag = (d < 0) ? -d : d;
      a = arc_angle(mag * pitch, 64'd16000 * focal);
      return (d < 0) ? -a : a;
    endfunction

    function void note_centre(bit [15:0] cx, bit [15:0] cy);
      tilt_beat_t r;
      int n, s0;
      bit [63:0] sx, sy, mx, my, rr;
      longint dh, dv, th, tv, tt;
      r = '0;
      // rejected centre or zero optics: all-zero beat, window untouched
      if (cx == 0 || pitch == 0 || focal == 0) begin
        pending.push_back(r);
        return;
      end
      s0 = slot;
      ring_x[s0] = cx;
      ring_y[s0] = cy;
      slot = (s0 + 1) % RING_DEPTH;
      n = avg_extra + 1;
      fill = fill + 1;
      if (fill > n) fill = n;   // also covers a shrunk window
      sx = 0;
      sy = 0;
      for (int k = 0; k < fill; k++) begin
        sx += ring_x[(s0 + RING_DEPTH - k) % RING_DEPTH];
        sy += ring_y[(s0 + RING_DEPTH - k) % RING_DEPTH];
      end
      mx = (sx + fill / 2) / fill;
      my = (sy + fill / 2) / fill;
      dh = longint'(mx) - longint'(base_x);
      dv = longint'(my) - longint'(base_y);
      rr = isqrt((dh * dh + dv * dv) << 16);
      tt = arc_angle(rr * pitch, 64'd4096000 * focal);
      th = axis_tilt(dh);
      tv = axis_tilt(dv);
      r.accepted = 1'b1;
      r.mean_x = mx[15:0];
      r.mean_y = my[15:0];
      r.offset_h = dh[16:0];
      r.offset_v = dv[16:0];
      r.tilt_total = tt[22:0];
      r.tilt_x = th[23:0];
      r.tilt_y = tv[23:0];
      pending.push_back(r);
    endfunction

    function void check_beat(tilt_beat_t got);
      tilt_beat_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.accepted !== want.accepted || got.mean_x !== want.mean_x ||
          got.mean_y !== want.mean_y || got.offset_h !== want.offset_h ||
          got.offset_v !== want.offset_v || got.tilt_total !== want.tilt_total ||
          got.tilt_x !== want.tilt_x || got.tilt_y !== want.tilt_y) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch at %0t", $realtime);
          $display("  expected %p", want);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] center_x = '0, center_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tilt_beat_t res;

  tilt_scoreboard sb = new();
  bit calm = 1'b0;          // no idling on either side
  int hold_asks = 0;        // bumped to request a long receiver hold
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  centroid_average_to_tilt_angle_unit u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .center_x(center_x), .center_y(center_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .accepted(res.accepted), .mean_x(res.mean_x), .mean_y(res.mean_y),
    .offset_h(res.offset_h), .offset_v(res.offset_v),
    .tilt_total(res.tilt_total), .tilt_x(res.tilt_x), .tilt_y(res.tilt_y)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: random stalls, plus a counted long hold when asked.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_asks != hold_served) begin
      hold_served <= hold_asks;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 8);
    end
  end

  // Beat monitor and watchdog. Values read here are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_centre(center_x, center_y);
      if (out_valid && !out_stall) sb.check_beat(res);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Offer one centre; returns right after the edge that takes it.
  task automatic send_centre(bit [15:0] cx, bit [15:0] cy);
    if (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    center_x <= cx;
    center_y <= cy;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // Stop offering and let every pending result drain; the unit is idle
  // once in_stall is low and nothing is expected.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending.size() != 0 || in_stall);
    @(posedge clk);
  endtask

  // Register write while idle: setup cycle, then access cycle.
  task automatic reg_write(logic [2:0] idx, bit [31:0] val);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Random centre: mostly near the base point, some full range, some rejects.
  task automatic send_random();
    int pick;
    bit [15:0] cx, cy;
    pick = $urandom_range(99);
    if (pick < 5) begin
      cx = 16'd0;
      cy = 16'($urandom);
    end else if (pick < 55) begin
      cx = sb.base_x + 16'($urandom_range(0, 1024)) - 16'd512;
      cy = sb.base_y + 16'($urandom_range(0, 1024)) - 16'd512;
      if (cx == 0) cx = 16'd1;
    end else begin
      cx = 16'($urandom_range(1, 65535));
      cy = 16'($urandom);
    end
    send_centre(cx, cy);
  endtask

  function automatic bit [31:0] pick_base();
    case ($urandom_range(3))
      0: return 32'd0;
      1: return 32'd65535;
      2: return 32'd16384;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reject, field extremes, centre on base, window grow/shrink
    send_centre(16'd0, 16'd1234);
    send_centre(16'd1, 16'd0);
    send_centre(16'hFFFF, 16'hFFFF);
    send_centre(16'd16384, 16'd16384);
    send_centre(16'd16385, 16'd16383);
    reg_write(REG_AVG, 32'd15);
    for (int i = 0; i < 5; i++) send_centre(16'($urandom_range(1, 65535)), 16'($urandom));
    send_centre(16'd0, 16'hFFFF);
    reg_write(REG_AVG, 32'd2);
    send_centre(16'd20000, 16'd12000);
    send_centre(16'd20010, 16'd12010);
    // zero optics behaves like a reject
    reg_write(REG_PITCH, 32'd0);
    send_centre(16'd30000, 16'd30000);
    reg_write(REG_PITCH, 32'd100000);
    reg_write(REG_FOCAL, 32'd1);
    send_centre(16'd40000, 16'd100);
    reg_write(REG_FOCAL, 32'd0);
    send_centre(16'd40000, 16'd100);
    reg_write(REG_FOCAL, 32'd1000000);
    reg_write(REG_PITCH, 32'd1);
    send_centre(16'd16400, 16'd16300);
    reg_write(REG_BASE_X, 32'd0);
    reg_write(REG_BASE_Y, 32'd65535);
    send_centre(16'hFFFF, 16'd0);
    send_centre(16'd1, 16'hFFFF);

    // random phases, each on its own settings
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(REG_BASE_X, pick_base());
      reg_write(REG_BASE_Y, pick_base());
      reg_write(REG_PITCH, (ph == 1) ? 32'd1 : (ph == 4) ? 32'd100000 :
                $urandom_range(1000, 20000));
      reg_write(REG_FOCAL, (ph == 1) ? 32'd1000000 : (ph == 4) ? 32'd1 :
                $urandom_range(10000, 300000));
      reg_write(REG_AVG, (ph == 0) ? 32'd0 : (ph == 2) ? 32'd15 :
                $urandom_range(0, 15));
      calm = (ph == 3);
      for (int i = 0; i < 105; i++) begin
        if (ph == 2 && i == 3) hold_asks++;   // fill up and stall the input
        send_random();
      end
      calm = 1'b0;
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
